// ===== design/sia_pkg.sv =====
// Package for the signed integer ALU/divide core.
// Types, operation codes and sizes shared by all design files; no dependencies.
package sia_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MOD = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]   kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic signed [31:0] remainder_part;
        logic               div_by_zero;
    } out_item_t;

    // classified item passed from front to back
    typedef struct packed {
        logic        is_add;
        logic        is_sub;
        logic        is_mul;
        logic        is_div;
        logic        is_mod;
        logic        dz;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] mag_a;
        logic [31:0] mag_b;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } cls_t;

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = 1;
    localparam int unsigned DSTG   = 32;

endpackage

// ===== design/sia_front.sv =====
// Front part: accepts a command and classifies it (op decode, signs, magnitudes).
// Uses sia_pkg.
module sia_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sia_pkg::in_item_t  cmd,
    output logic               busy,
    output logic               cls_valid,
    output sia_pkg::cls_t      cls
);

    logic          valid_reg;
    sia_pkg::cls_t cls_reg;
    sia_pkg::cls_t cls_next;
    logic          bz;

    assign busy = 1'b0;

    always_comb
    begin
        bz = (cmd.operand_b == 32'sd0);
        cls_next        = '0;
        cls_next.is_add = (cmd.kind == sia_pkg::OP_ADD);
        cls_next.is_sub = (cmd.kind == sia_pkg::OP_SUB);
        cls_next.is_mul = (cmd.kind == sia_pkg::OP_MUL);
        cls_next.is_div = (cmd.kind == sia_pkg::OP_DIV);
        cls_next.is_mod = (cmd.kind == sia_pkg::OP_MOD);
        cls_next.dz     = bz && (cls_next.is_div || cls_next.is_mod);
        cls_next.neg_r  = cmd.operand_a[31];
        cls_next.neg_q  = cmd.operand_a[31] ^ cmd.operand_b[31];
        cls_next.mag_a  = cmd.operand_a[31] ? (32'd0 - cmd.operand_a) : cmd.operand_a;
        cls_next.mag_b  = cmd.operand_b[31] ? (32'd0 - cmd.operand_b) : cmd.operand_b;
        cls_next.a      = cmd.operand_a;
        cls_next.b      = cmd.operand_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

// ===== design/sia_queue.sv =====
// Short FIFO between front and back parts.
// Uses sia_pkg.
module sia_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sia_pkg::cls_t  wr_data,
    input  logic           rd_en,
    output logic           rd_valid,
    output sia_pkg::cls_t  rd_data
);

    sia_pkg::cls_t mem [sia_pkg::QDEPTH];
    logic [sia_pkg::QAW-1:0] wp_reg;
    logic [sia_pkg::QAW-1:0] rp_reg;
    logic [sia_pkg::QAW:0]   cnt_reg;
    logic                    do_rd;

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{sia_pkg::QAW{1'b0}}, wr_en}
                               - {{sia_pkg::QAW{1'b0}}, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

endmodule

// ===== design/sia_back.sv =====
// Back part: 32-stage pipelined restoring divider with a registered multiplier
// and adder alongside, result aligned at the end. Uses sia_pkg.
module sia_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  sia_pkg::cls_t      cls,
    output logic               done,
    output sia_pkg::out_item_t result
);

    localparam int unsigned N = sia_pkg::DSTG;

    logic               v_reg   [N+1];
    sia_pkg::cls_t      c_reg   [N+1];
    logic [31:0]        q_reg   [N+1];
    logic [31:0]        r_reg   [N+1];
    logic signed [63:0] m_reg   [N+1];
    logic [32:0]        trial   [N];
    logic [32:0]        shifted [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            shifted[i] = {r_reg[i], q_reg[i][31]};
            trial[i]   = shifted[i] - {1'b0, c_reg[i].mag_b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= N; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < N; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg[0] <= cls;
        q_reg[0] <= cls.mag_a;
        r_reg[0] <= '0;
        if (cls.is_mul)
        begin
            m_reg[0] <= 64'(cls.a) * 64'(cls.b);
        end
        else if (cls.is_sub)
        begin
            m_reg[0] <= 64'(cls.a) - 64'(cls.b);
        end
        else
        begin
            m_reg[0] <= 64'(cls.a) + 64'(cls.b);
        end
        for (int i = 0; i < N; i++)
        begin
            c_reg[i+1] <= c_reg[i];
            m_reg[i+1] <= m_reg[i];
            if (!trial[i][32])
            begin
                r_reg[i+1] <= trial[i][31:0];
                q_reg[i+1] <= {q_reg[i][30:0], 1'b1};
            end
            else
            begin
                r_reg[i+1] <= shifted[i][31:0];
                q_reg[i+1] <= {q_reg[i][30:0], 1'b0};
            end
        end
    end

    logic signed [63:0] qs;
    logic signed [31:0] rs;
    sia_pkg::cls_t      cf;

    always_comb
    begin
        cf = c_reg[N];
        qs = cf.neg_q ? (64'sd0 - $signed({32'd0, q_reg[N]})) : $signed({32'd0, q_reg[N]});
        rs = cf.neg_r ? (32'sd0 - $signed(r_reg[N])) : $signed(r_reg[N]);
        result = '0;
        if (cf.dz)
        begin
            result.div_by_zero = 1'b1;
        end
        else if (cf.is_div)
        begin
            result.value          = qs;
            result.remainder_part = rs;
        end
        else if (cf.is_mod)
        begin
            result.value = 64'(rs);
        end
        else if (cf.is_add || cf.is_sub || cf.is_mul)
        begin
            result.value = m_reg[N];
        end
    end

    assign done = v_reg[N];

endmodule

// ===== design/signed_integer_alu_divide_core.sv =====
// Top level of the signed integer ALU/divide core.
// Instantiates sia_front, sia_queue and sia_back; uses sia_pkg.
//
//  channel | ports               | handshake
//  --------+---------------------+---------------------------------
//  command | start, busy, cmd    | taken when start && !busy
//  result  | done, result        | one-cycle strobe, no back-pressure
//
// One item per cycle; each command passes the classify register, the queue and the
// registered stages of the one-bit-per-stage divider pipeline before its result appears.
// busy stays low; the receiver cannot stall, so the queue never fills.
// Reset clears all valid flags; payload registers are not reset.
module signed_integer_alu_divide_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sia_pkg::in_item_t  cmd,
    output logic               busy,
    output logic               done,
    output sia_pkg::out_item_t result
);

    logic          f_valid;
    sia_pkg::cls_t f_cls;
    logic          q_valid;
    sia_pkg::cls_t q_cls;

    sia_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .cls_valid (f_valid),
        .cls       (f_cls)
    );

    sia_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_valid),
        .wr_data  (f_cls),
        .rd_en    (1'b1),
        .rd_valid (q_valid),
        .rd_data  (q_cls)
    );

    sia_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .cls      (q_cls),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for signed_integer_alu_divide_core: directed table, then random commands.
// Expected results come from the directed table or a local model of the ALU; depends on sia_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 35;
    localparam int N_RANDOM  = 1830;
    localparam int MAX_CYCLE = 200000;

    typedef struct {
        logic [2:0]         kind;
        logic [31:0]        a;
        logic [31:0]        b;
        bit                 known;
        sia_pkg::out_item_t res;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    sia_pkg::in_item_t  cmd;
    logic               busy;
    logic               done;
    sia_pkg::out_item_t result;

    sia_pkg::out_item_t alu_expected[$];
    int                 errors;
    int                 cycle_count;
    int                 idle_pct;
    dir_row_t           dir_rows[$];

    signed_integer_alu_divide_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sia_pkg::out_item_t alu_compute(logic [2:0] kind,
                                                       logic [31:0] a_bits,
                                                       logic [31:0] b_bits);
        longint             a;
        longint             b;
        sia_pkg::out_item_t r;
        a = longint'(signed'(a_bits));
        b = longint'(signed'(b_bits));
        r = '0;
        case (kind)
            sia_pkg::OP_ADD: r.value = a + b;
            sia_pkg::OP_SUB: r.value = a - b;
            sia_pkg::OP_MUL: r.value = a * b;
            sia_pkg::OP_DIV:
                if (b == 0)
                    r.div_by_zero = 1'b1;
                else
                begin
                    r.value          = a / b;
                    r.remainder_part = 32'(a % b);
                end
            sia_pkg::OP_MOD:
                if (b == 0)
                    r.div_by_zero = 1'b1;
                else
                    r.value = a % b;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic sia_pkg::out_item_t mk(longint v, int rm, bit dz);
        sia_pkg::out_item_t r;
        r.value          = v;
        r.remainder_part = rm;
        r.div_by_zero    = dz;
        return r;
    endfunction

    task automatic add_row(logic [2:0] kind, logic [31:0] a, logic [31:0] b, bit known,
                           sia_pkg::out_item_t res);
        dir_row_t row;
        row.kind  = kind;
        row.a     = a;
        row.b     = b;
        row.known = known;
        row.res   = res;
        dir_rows.push_back(row);
    endtask

    // one transfer; sender gap before it per idle_pct
    task automatic send_cmd(logic [2:0] kind, logic [31:0] a, logic [31:0] b, bit known,
                            sia_pkg::out_item_t res);
        sia_pkg::in_item_t item;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        item.kind      = kind;
        item.operand_a = a;
        item.operand_b = b;
        start <= 1'b1;
        cmd   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        alu_expected.push_back(known ? res : alu_compute(kind, a, b));
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(16)) - 8);
            3: return 32'($urandom_range(65535));
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (alu_expected.size() == 0)
            begin
                $display("%0t: unexpected result value=%h rem=%h dz=%b", $time,
                         result.value, result.remainder_part, result.div_by_zero);
                errors++;
            end
            else
            begin
                sia_pkg::out_item_t e;
                e = alu_expected.pop_front();
                if (result.value !== e.value)
                begin
                    $display("%0t: value expected %h actual %h", $time, e.value,
                             result.value);
                    errors++;
                end
                if (result.remainder_part !== e.remainder_part)
                begin
                    $display("%0t: remainder_part expected %h actual %h", $time,
                             e.remainder_part, result.remainder_part);
                    errors++;
                end
                if (result.div_by_zero !== e.div_by_zero)
                begin
                    $display("%0t: div_by_zero expected %b actual %b", $time,
                             e.div_by_zero, result.div_by_zero);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] k;
        int         wait_cycles;
        errors      = 0;
        cycle_count = 0;
        idle_pct    = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;

        add_row(sia_pkg::OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 1,
                mk(64'sd4294967294, 0, 0));
        add_row(sia_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 1,
                mk(-64'sd4294967296, 0, 0));
        add_row(sia_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 1,
                mk(-64'sd4294967295, 0, 0));
        add_row(sia_pkg::OP_SUB, 32'h7fff_ffff, 32'h8000_0000, 1,
                mk(64'sd4294967295, 0, 0));
        add_row(sia_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 1,
                mk(64'sh4000_0000_0000_0000, 0, 0));
        add_row(sia_pkg::OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 1,
                mk(-64'sh3fff_ffff_8000_0000, 0, 0));
        add_row(sia_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1, mk(1, 0, 0));
        add_row(sia_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1,
                mk(64'sd2147483648, 0, 0));
        add_row(sia_pkg::OP_MOD, 32'h8000_0000, 32'hffff_ffff, 1, mk(0, 0, 0));
        add_row(sia_pkg::OP_DIV, 32'd7, 32'd0, 1, mk(0, 0, 1));
        add_row(sia_pkg::OP_MOD, 32'h8000_0000, 32'd0, 1, mk(0, 0, 1));
        add_row(sia_pkg::OP_DIV, -32'sd7, 32'd2, 1, mk(-3, -1, 0));
        add_row(sia_pkg::OP_DIV, 32'd7, -32'sd2, 1, mk(-3, 1, 0));
        add_row(sia_pkg::OP_MOD, -32'sd7, -32'sd2, 1, mk(-1, 0, 0));
        add_row(sia_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 0, '0);
        add_row(sia_pkg::OP_DIV, 32'h8000_0000, 32'h7fff_ffff, 0, '0);
        add_row(sia_pkg::OP_MOD, 32'h7fff_ffff, 32'd10, 0, '0);
        add_row(3'd5, 32'hffff_ffff, 32'hffff_ffff, 1, mk(0, 0, 0));
        add_row(3'd6, 32'd1, 32'd0, 1, mk(0, 0, 0));
        add_row(3'd7, 32'h8000_0000, 32'd0, 1, mk(0, 0, 0));
        add_row(sia_pkg::OP_ADD, 32'd0, 32'd0, 1, mk(0, 0, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].kind, dir_rows[i].a, dir_rows[i].b, dir_rows[i].known,
                     dir_rows[i].res);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n < N_RANDOM / 3)
                idle_pct = 34;
            else if (n < 2 * N_RANDOM / 3)
                idle_pct = 84;
            else
                idle_pct = 0;
            k = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
            send_cmd(k, rand_operand(), ($urandom_range(19) == 0) ? 32'd0 : rand_operand(),
                     0, '0);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (alu_expected.size() != 0 && wait_cycles < 10 * LATENCY)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(posedge clk);

        if (errors == 0 && alu_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
